FILE: sv/ttemp_pkg.sv
// Shared constants, types and state codes of the tap tempo estimator.
`default_nettype none

package ttemp_pkg;

	// Tap history
	localparam int WINDOW = 8;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// Field widths
	localparam int TIME_W     = 32;
	localparam int TR_W       = 24;
	localparam int BPM_W      = 11;
	localparam int OUT_DATA_W = 16;

	// Fold limits: 60 and 180 BPM in tenths with 8 fraction bits
	localparam int FOLD_LOW   = 153600;
	localparam int FOLD_HIGH  = 460800;
	localparam int FOLD_LOW_W = 18;
	localparam int K_W        = FOLD_LOW_W + SLOT_W;

	// Datapath widths
	localparam int NUM_W  = (TR_W + K_W + 1 > 52) ? TR_W + K_W + 1 : 52;
	localparam int MB_W   = (K_W > NUM_W - TIME_W) ? K_W : NUM_W - TIME_W;
	localparam int PROD_W = TIME_W + MB_W;
	localparam int DEN_W  = TIME_W + 1;
	localparam int Q_W    = 19;
	localparam int QCNT_W = $clog2(Q_W);
	localparam int FRAC_W = 8;
	localparam int ROUND_HALF = 128;

	// Register port
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TICK_RATE = '0;
	localparam logic [TR_W-1:0] TICK_RATE_RESET = TR_W'(1000000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FOLD_LO,
		ST_FOLD_HI,
		ST_DIV,
		ST_DONE
	} state_t;

	// What the tap history says about the tap being pushed
	typedef struct packed {
		logic              emit;
		logic [SLOT_W-1:0] intervals;
		logic [TIME_W-1:0] oldest;
	} ring_info_t;

endpackage

`default_nettype wire

FILE: sv/ttemp_mul.sv
// Shared unsigned multiplier of the tap tempo estimator.
`default_nettype none

module ttemp_mul (
	input  logic [ttemp_pkg::TIME_W-1:0] a,
	input  logic [ttemp_pkg::MB_W-1:0]   b,
	output logic [ttemp_pkg::PROD_W-1:0] p
);
	import ttemp_pkg::*;

	assign p = PROD_W'(a) * PROD_W'(b);

endmodule

`default_nettype wire

FILE: sv/ttemp_alu.sv
// Shared subtract and compare unit of the tap tempo estimator.
`default_nettype none

module ttemp_alu (
	input  logic [ttemp_pkg::NUM_W-1:0] a,
	input  logic [ttemp_pkg::NUM_W-1:0] b,
	output logic                        ge,
	output logic [ttemp_pkg::NUM_W-1:0] diff
);
	import ttemp_pkg::*;

	logic borrow;

	// a >= b exactly when the subtraction does not borrow
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

`default_nettype wire

FILE: sv/ttemp_ring.sv
// Tap history ring with fill count and write pointer.
`default_nettype none

module ttemp_ring (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [ttemp_pkg::TIME_W-1:0] tap_time,
	output ttemp_pkg::ring_info_t        info
);
	import ttemp_pkg::*;

	logic [TIME_W-1:0] tap_ring_q [WINDOW];
	logic [CNT_W-1:0]  tap_count_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [SLOT_W-1:0] slot_nxt;

	assign count_nxt = (tap_count_q < CNT_W'(WINDOW)) ? tap_count_q + CNT_W'(1) : tap_count_q;
	assign slot_nxt  = (write_slot_q == SLOT_W'(WINDOW - 1)) ? '0 : write_slot_q + SLOT_W'(1);

	// Oldest kept tap: slot 0 while filling, else the slot written next.
	// Neither is the slot being written now, except at the first tap, which emits nothing.
	always_comb begin
		info.emit      = (count_nxt >= CNT_W'(2));
		info.intervals = SLOT_W'(count_nxt - CNT_W'(1));
		info.oldest    = (count_nxt == CNT_W'(WINDOW)) ? tap_ring_q[slot_nxt] : tap_ring_q[0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tap_ring_q[write_slot_q] <= tap_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= '0;
			write_slot_q <= '0;
		end else if (push) begin
			tap_count_q  <= count_nxt;
			write_slot_q <= slot_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tap_tempo_estimator_top.sv
// Top level of the tap tempo estimator: sequencer, datapath and ports.
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) takes one tap item: the
//    32-bit tick counter value at the tap. An item moves when tvalid and
//    tready are both high at a rising edge.
//  - Master stream (m_tvalid/m_tready/m_tdata/m_tuser) gives one result
//    item per tap from the second tap on: tempo in tenths of BPM (600 to
//    1800, else 0) in m_tdata, span error flag in m_tuser. The first tap gives none.
//  - APB port holds tick_rate (ticks per second) at byte address 0; write
//    it only while the block is idle. pready is tied high.
//  - Sequence: a zero span or zero rate goes from accept straight to the
//    done state with tempo 0; else the shared multiplier forms num, lo
//    and hi in turn, each fold compare and doubling runs on the shared
//    subtractor, then a divide yields the 19-bit quotient.
//  - Throughput: one tap at a time; s_tready is low from the accept of a
//    tap that gives an item until that item is in the output register.
//  - Stall: hold a finished item in the output register while m_tready is
//    low; the next tap is still taken, and its item waits in the done state
//    only while the output register is still full.
//  - Reset (arst_n low): empty tap history, tick_rate = 1000000, no item.
`default_nettype none

module tap_tempo_estimator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ttemp_pkg::ADDR_W-1:0]     paddr,
	input  logic [ttemp_pkg::DATA_W-1:0]     pwdata,
	output logic [ttemp_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,
	// Tap stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ttemp_pkg::TIME_W-1:0]     s_tdata,   // [31:0] tap_time
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ttemp_pkg::OUT_DATA_W-1:0] m_tdata,   // [10:0] bpm_tenths, [15:11] zero
	output logic                             m_tuser    // [0] span_error
);
	import ttemp_pkg::*;

	state_t state_q, state_nxt;

	logic [TR_W-1:0]   tick_rate_q;
	logic [MB_W-1:0]   k_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  lo_q;
	logic [NUM_W-1:0]  hi_q;
	logic [Q_W-1:0]    q_q;
	logic [QCNT_W-1:0] step_q;
	logic              res_err_q;
	logic              out_valid_q;
	logic [BPM_W-1:0]  out_bpm_q;
	logic              out_err_q;

	logic              accept;
	logic              load_out;
	logic              cfg_write;
	logic [TIME_W-1:0] span;
	logic              early_done;
	ring_info_t        info;

	logic [TIME_W-1:0] mul_a;
	logic [MB_W-1:0]   mul_b;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  alu_a;
	logic [NUM_W-1:0]  alu_b;
	logic              alu_ge;
	logic [NUM_W-1:0]  alu_diff;
	logic [Q_W:0]      q_rounded;

	// ---------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RESET;
		end else if (cfg_write && paddr[ADDR_W-1:2] == REG_TICK_RATE) begin
			tick_rate_q <= pwdata[TR_W-1:0];
		end
	end

	assign prdata = (paddr[ADDR_W-1:2] == REG_TICK_RATE) ? DATA_W'(tick_rate_q) : '0;

	// ---------------------------------------------------------------
	// Tap history
	// ---------------------------------------------------------------
	assign accept = s_tvalid & s_tready;

	ttemp_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.tap_time (s_tdata),
		.info     (info)
	);

	// Span wraps modulo 2^32, so counter rollover needs no care
	assign span = s_tdata - info.oldest;
	// Zero span or zero tick rate: result is known at once
	assign early_done = (span == '0) || (tick_rate_q == '0);

	// ---------------------------------------------------------------
	// Shared units
	// ---------------------------------------------------------------
	always_comb begin
		mul_a = den_q[TIME_W-1:0];
		mul_b = MB_W'(FOLD_LOW);
		case (state_q)
			ST_MUL_NUM: begin
				mul_a = TIME_W'(tick_rate_q);
				mul_b = k_q;
			end
			ST_MUL_HI: begin
				mul_b = MB_W'(FOLD_HIGH);
			end
			default: begin
				mul_b = MB_W'(FOLD_LOW);
			end
		endcase
	end

	ttemp_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (prod)
	);

	// Fold high compares hi against num; fold low and divide use num against lo
	always_comb begin
		if (state_q == ST_FOLD_HI) begin
			alu_a = hi_q;
			alu_b = num_q;
		end else begin
			alu_a = num_q;
			alu_b = lo_q;
		end
	end

	ttemp_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.ge   (alu_ge),
		.diff (alu_diff)
	);

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && info.emit) begin
					state_nxt = early_done ? ST_DONE : ST_MUL_NUM;
				end
			end
			ST_MUL_NUM: state_nxt = ST_MUL_LO;
			ST_MUL_LO:  state_nxt = ST_MUL_HI;
			ST_MUL_HI:  state_nxt = ST_FOLD_LO;
			ST_FOLD_LO: begin
				if (alu_ge) begin
					state_nxt = ST_FOLD_HI;
				end
			end
			ST_FOLD_HI: begin
				if (alu_ge) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs
	// ---------------------------------------------------------------
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DONE: load_out = ~out_valid_q | m_tready;
			default: begin
				s_tready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Datapath. Tempo is NUM/DEN with NUM = 153600 * rate * intervals
	// and DEN = span; lo and hi track the fold limits times DEN.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					den_q     <= DEN_W'(span);
					k_q       <= MB_W'(FOLD_LOW) * MB_W'(info.intervals);
					q_q       <= '0;
					res_err_q <= (span == '0);
				end
			end
			ST_MUL_NUM: num_q <= prod[NUM_W-1:0];
			ST_MUL_LO:  lo_q  <= prod[NUM_W-1:0];
			ST_MUL_HI:  hi_q  <= prod[NUM_W-1:0];
			ST_FOLD_LO: begin
				// Double the tempo while below 60 BPM
				if (!alu_ge) begin
					num_q <= num_q << 1;
				end
			end
			ST_FOLD_HI: begin
				// Halve the tempo while above 180 BPM, else set up the divide
				if (!alu_ge) begin
					den_q <= den_q << 1;
					hi_q  <= hi_q << 1;
				end else begin
					lo_q   <= NUM_W'(den_q) << (Q_W - 1);
					step_q <= QCNT_W'(Q_W - 1);
				end
			end
			ST_DIV: begin
				// One quotient bit per cycle, divisor shifting down
				if (alu_ge) begin
					num_q <= alu_diff;
				end
				q_q    <= {q_q[Q_W-2:0], alu_ge};
				lo_q   <= lo_q >> 1;
				step_q <= step_q - QCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Output register: round to the nearest tenth, a half rounds up
	// ---------------------------------------------------------------
	assign q_rounded = (Q_W + 1)'(q_q) + (Q_W + 1)'(ROUND_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_bpm_q <= q_rounded[FRAC_W +: BPM_W];
			out_err_q <= res_err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_bpm_q);
	assign m_tuser  = out_err_q;

endmodule

`default_nettype wire

FILE: test/tb_tap_tempo_estimator_top.sv
// Self-checking testbench of the tap tempo estimator: directed table, then random tap phases.
`timescale 1ns / 1ps

module tb_tap_tempo_estimator_top;
	import ttemp_pkg::*;

	// Bench timing and sizes
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_HOLD  = 80;    // covers the longest fold and divide
	localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer at all
	localparam int PHASES       = 8;
	localparam int RANDOM_TAPS  = 1880;

	// Register byte addresses: tick_rate, and one slot past the register list
	localparam logic [ADDR_W-1:0] ADDR_TICK_RATE = {REG_TICK_RATE, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = ADDR_TICK_RATE + ADDR_W'(4);

	typedef struct {
		logic [BPM_W-1:0] bpm;
		logic             err;
	} tempo_result_t;

	typedef enum logic {
		ROW_TAP,
		ROW_REG
	} row_kind_t;

	// One line of the directed table: a tap or a register write. Where typed is set,
	// the result is read straight from the row instead of the tempo predictor.
	typedef struct {
		row_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       value;
		bit                typed;
		bit                yields;
		logic [BPM_W-1:0]  bpm;
		logic              err;
	} stim_row_t;

	localparam int DIR_ROWS = 23;

	// Rows run in order from reset (tick_rate 1000000, empty history)
	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		// first tap after reset: stored, no item out
		'{ROW_TAP, ADDR_TICK_RATE, 32'd0,          1'b1, 1'b0, 11'd0,    1'b0},
		// half a second per beat: exactly 120 BPM
		'{ROW_TAP, ADDR_TICK_RATE, 32'd500000,     1'b1, 1'b1, 11'd1200, 1'b0},
		// newest equals oldest: span error
		'{ROW_TAP, ADDR_TICK_RATE, 32'd0,          1'b1, 1'b1, 11'd0,    1'b1},
		// three intervals over one second: exactly the 180 BPM ceiling
		'{ROW_TAP, ADDR_TICK_RATE, 32'd1000000,    1'b1, 1'b1, 11'd1800, 1'b0},
		// very long spans and extremes of the timestamp
		'{ROW_TAP, ADDR_TICK_RATE, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h7FFF_FFFF,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h8000_0000,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0,    1'b0},
		// window full, counter rolled over since the oldest kept tap
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0000_1000,  1'b0, 1'b0, 11'd0,    1'b0},
		// zero tick rate: no tempo, no error
		'{ROW_REG, ADDR_TICK_RATE, 32'd0,          1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0000_2000,  1'b1, 1'b1, 11'd0,    1'b0},
		// zero span still flags the error at zero rate
		'{ROW_TAP, ADDR_TICK_RATE, 32'd1000000,    1'b1, 1'b1, 11'd0,    1'b1},
		// all-ones write: only the low 24 bits land
		'{ROW_REG, ADDR_TICK_RATE, 32'hFFFF_FFFF,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0100_0000,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0300_0000,  1'b0, 1'b0, 11'd0,    1'b0},
		// write past the register list: ignored
		'{ROW_REG, ADDR_UNMAPPED,  32'd1234,       1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0300_4000,  1'b0, 1'b0, 11'd0,    1'b0},
		// slowest and fastest tick rates in use
		'{ROW_REG, ADDR_TICK_RATE, 32'd1000,       1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0300_41F4,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0300_43E8,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_REG, ADDR_TICK_RATE, 32'd10000000,   1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h0350_0000,  1'b0, 1'b0, 11'd0,    1'b0},
		'{ROW_TAP, ADDR_TICK_RATE, 32'h03A0_0000,  1'b0, 1'b0, 11'd0,    1'b0}
	};

	// Block ports, every input at a known value from time zero
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_W-1:0]     paddr    = '0;
	logic [DATA_W-1:0]     pwdata   = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TIME_W-1:0]     s_tdata  = '0;  // [31:0] tap_time
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [10:0] bpm_tenths, [15:11] zero
	logic                  m_tuser;        // [0] span_error

	// Tempo predictor state: tap history, kept count, next slot, tick rate
	logic [TIME_W-1:0] tap_hist [WINDOW];
	int unsigned       kept      = 0;
	int unsigned       next_slot = 0;
	logic [TR_W-1:0]   rate_setting = TICK_RATE_RESET;

	tempo_result_t     tempo_pending [$];  // tempo items still owed by the block
	int unsigned       fails = 0;
	int unsigned       quiet_cycles = 0;
	logic [15:0]       ready_pat = '1;
	logic [3:0]        ready_idx = '0;
	logic [TIME_W-1:0] last_tap = '0;
	logic [TIME_W-1:0] beat_ticks = 32'd1000;

	tap_tempo_estimator_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Exact fold of 153600 * rate * intervals / span into 60..180 BPM, then round
	// to the nearest tenth (a half rounds up).
	function automatic logic [BPM_W-1:0] fold_tempo(input logic [TIME_W-1:0] span,
			input int unsigned intervals);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		num = 64'(FOLD_LOW) * 64'(rate_setting) * 64'(intervals);
		den = 64'(span);
		while (num < 64'(FOLD_LOW) * den)
			num = num << 1;
		while (num > 64'(FOLD_HIGH) * den)
			den = den << 1;
		q = num / den;
		return BPM_W'((q + 64'(ROUND_HALF)) >> FRAC_W);
	endfunction

	// Push one tap into the predicted history; returns 1 when a tempo item is due
	function automatic bit tempo_push(input logic [TIME_W-1:0] now, output tempo_result_t res);
		logic [TIME_W-1:0] oldest;
		logic [TIME_W-1:0] span;
		tap_hist[next_slot] = now;
		next_slot = (next_slot + 1) % WINDOW;
		if (kept < WINDOW)
			kept++;
		res.bpm = '0;
		res.err = 1'b0;
		if (kept < 2)
			return 1'b0;
		oldest = (kept >= WINDOW) ? tap_hist[next_slot] : tap_hist[0];
		span = now - oldest;
		if (span == '0)
			res.err = 1'b1;
		else if (rate_setting != '0)
			res.bpm = fold_tempo(span, kept - 1);
		return 1'b1;
	endfunction

	// The tap that will be the oldest kept one once the next tap is pushed
	function automatic logic [TIME_W-1:0] oldest_after_push();
		return (kept >= WINDOW - 1) ? tap_hist[(next_slot + 1) % WINDOW] : tap_hist[0];
	endfunction

	// Offer one tap and hold it until the block takes it; then predict its item.
	// Valid stays high afterwards: the caller either offers the next tap or drops it.
	task automatic send_tap(input logic [TIME_W-1:0] t, input bit typed, input bit yields,
			input logic [BPM_W-1:0] bpm, input logic err);
		tempo_result_t res;
		bit            due;
		s_tdata  <= t;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		due = tempo_push(t, res);
		if (typed) begin
			due     = yields;
			res.bpm = bpm;
			res.err = err;
		end
		if (due)
			tempo_pending = {tempo_pending, res};
	endtask

	// Drop valid, wait for every owed item, then hold while a tap with no item
	// may still be in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tempo_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_HOLD)
			@(posedge clk);
	endtask

	// Register write (setup, access), then read tick_rate back and check it
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr[ADDR_W-1:2] == REG_TICK_RATE)
			rate_setting = data[TR_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TICK_RATE;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== DATA_W'(rate_setting)) begin
			$display("%0t: tick_rate read back: expected %h, actual %h",
				$time, DATA_W'(rate_setting), prdata);
			fails++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a fresh beat length: a tempo between 30 and 300 BPM, or 1 to 2^20 ticks at zero rate
	task automatic new_beat();
		if (rate_setting == '0)
			beat_ticks = $urandom_range(1, 1 << 20);
		else
			beat_ticks = 32'((64'(rate_setting) * 600) / $urandom_range(300, 3000));
	endtask

	// One random phase: mostly steady tapping with jitter and tempo changes,
	// the rest stray timestamps, repeated taps, zero spans and near-zero beats
	task automatic run_phase(input int n, input bit gapless);
		int          k;
		int          burst_left;
		int unsigned pick;
		logic [TIME_W-1:0] t;
		burst_left = gapless ? n : $urandom_range(1, 16);
		last_tap   = $urandom();
		new_beat();
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				if ($urandom_range(0, 31) == 0)
					new_beat();
				t = last_tap + beat_ticks - beat_ticks / 32 + $urandom_range(0, beat_ticks / 16);
			end else if (pick < 88) begin
				t = $urandom();
			end else if (pick < 94) begin
				t = oldest_after_push();
			end else if (pick < 97) begin
				t = last_tap;
			end else begin
				t = last_tap + $urandom_range(1, 3);
			end
			last_tap = t;
			send_tap(t, 1'b0, 1'b0, '0, 1'b0);
			burst_left--;
			// End of a burst: drop valid for a random gap, unless this is the last tap
			if (burst_left == 0 && k != n - 1) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Receiver: stall on a rotating 16-bit pattern that each phase reloads
	always @(posedge clk) begin
		ready_idx <= ready_idx + 4'd1;
		m_tready  <= ready_pat[ready_idx];
	end

	// Check every tempo item against the oldest one owed
	always @(posedge clk) begin
		tempo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (tempo_pending.size() == 0) begin
				$display("%0t: tempo item with none owed: expected nothing, actual bpm %0d err %b",
					$time, m_tdata[BPM_W-1:0], m_tuser);
				fails++;
			end else begin
				want = tempo_pending.pop_front();
				if (m_tdata[BPM_W-1:0] !== want.bpm) begin
					$display("%0t: bpm_tenths: expected %0d, actual %0d",
						$time, want.bpm, m_tdata[BPM_W-1:0]);
					fails++;
				end
				if (m_tuser !== want.err) begin
					$display("%0t: span_error: expected %b, actual %b",
						$time, want.err, m_tuser);
					fails++;
				end
			end
		end
	end

	// Count cycles in which nothing moves on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Watchdog: end the run once the block has been stuck too long
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int r;
		int ph;
		logic [TR_W-1:0] rate;
		for (r = 0; r < WINDOW; r++)
			tap_hist[r] = '0;

		// Hold reset, then release it on a rising edge
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: taps go back to back; register rows wait for the block to idle
		for (r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_REG) begin
				settle();
				reg_write(dir_rows[r].addr, dir_rows[r].value);
			end else begin
				send_tap(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].yields,
					dir_rows[r].bpm, dir_rows[r].err);
			end
		end

		// Random phases, each under a new tick rate and a new stall pattern;
		// every third phase runs with no sender gaps and no receiver stalls
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			case ($urandom_range(0, 7))
				0:       rate = TR_W'($urandom_range(0, 24'hFFFFFF));
				1:       rate = TR_W'($urandom_range(1000, 2000));
				default: rate = TR_W'($urandom_range(1000, 10000000));
			endcase
			reg_write(ADDR_TICK_RATE, {8'($urandom()), rate});
			if (ph % 3 == 0)
				ready_pat <= '1;
			else
				ready_pat <= 16'($urandom()) | 16'h0001;
			run_phase(RANDOM_TAPS / PHASES, ph % 3 == 0);
		end

		// Drain: wait for every owed item, then let the block run on a little
		s_tvalid <= 1'b0;
		while (tempo_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_HOLD)
			@(posedge clk);

		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
sv/ttemp_pkg.sv
sv/ttemp_mul.sv
sv/ttemp_alu.sv
sv/ttemp_ring.sv
sv/tap_tempo_estimator_top.sv
test/tb_tap_tempo_estimator_top.sv
